### hw/rtl/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants
// Payload structs, action and status codes, table geometry.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int SLOTS       = 8;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_ADD     = 3'd1,
        ACT_DELETE  = 3'd2,
        ACT_ENABLE  = 3'd3,
        ACT_DISABLE = 3'd4,
        ACT_TOGGLE  = 3'd5,
        ACT_RESTART = 3'd6,
        ACT_QUERY   = 3'd7
    } action_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic [15:0] timer_id;
        logic [31:0] interval_ms;
        logic [15:0] run_limit;
    } in_item_t;

    typedef struct packed {
        logic [15:0] result_id;
        logic        fired;
        logic        removed;
        logic [1:0]  status;
        logic        enabled_out;
        logic [31:0] interval_out;
        logic [31:0] last_due_out;
        logic [31:0] remaining_ms;
        logic [31:0] elapsed_ms;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] interval;
        logic [31:0] last_due;
        logic [15:0] limit;
        logic [15:0] runs;
        logic        enabled;
    } entry_t;

endpackage
`default_nettype wire

### hw/rtl/ptt_table_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_table_ram: timer entry store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptt_table_ram (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ptt_pkg::SLOT_W-1:0] waddr,
    input  wire ptt_pkg::entry_t          wdata,
    input  wire logic [ptt_pkg::SLOT_W-1:0] raddr,
    output ptt_pkg::entry_t               rdata
);

    ptt_pkg::entry_t mem [ptt_pkg::SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/periodic_timer_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_table_core: insertion-ordered interval timer table
// Tick scans, add, delete, enable/disable/toggle, restart and query by id.
// ----------------------------------------------------------------------------
// channel | direction | payload     | handshake
// in      | input     | in_item_t   | in_valid / in_ready
// out     | output    | out_item_t  | out_valid / out_ready
//
// Scan transactions pass S_READ (RAM read) and S_EVAL (modify/write back with
// compaction) per entry, then S_FINAL and S_WAIT; the result is registered on
// leaving S_WAIT, and the next transaction is accepted in the S_IDLE after it.
// A tick result after the first waits in S_EVAL until the staged one is taken;
// output stalls hold the scan too. Add: RAM write on acceptance, result via S_WAIT.
// Reset clears count, id counter and control; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module periodic_timer_table_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ptt_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ptt_pkg::out_item_t      out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_COPY,
        S_FINAL,
        S_WAIT
    } state_t;

    state_t                      state_reg;
    ptt_pkg::in_item_t           item_reg;
    logic [ptt_pkg::CNT_W-1:0]   count_reg;
    logic [15:0]                 idc_reg;
    logic [ptt_pkg::CNT_W-1:0]   rd_reg;
    logic [ptt_pkg::CNT_W-1:0]   wr_reg;
    logic [ptt_pkg::NRES_W-1:0]  nres_reg;
    logic                        found_reg;
    logic                        out_valid_reg;
    ptt_pkg::out_item_t          out_reg;
    ptt_pkg::out_item_t          pend_reg;
    logic                        pend_valid_reg;

    logic                        we;
    logic [ptt_pkg::SLOT_W-1:0]  waddr;
    ptt_pkg::entry_t             wdata;
    logic [ptt_pkg::SLOT_W-1:0]  raddr;
    ptt_pkg::entry_t             rdata;

    ptt_table_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // per-entry evaluation
    ptt_pkg::entry_t    upd;
    logic               keep;
    logic               emit;
    logic               rem;
    logic               due;
    logic               match;
    logic [31:0]        elapsed;
    ptt_pkg::out_item_t res;

    always_comb
    begin
        upd     = rdata;
        keep    = 1'b1;
        emit    = 1'b0;
        rem     = 1'b0;
        elapsed = item_reg.now_ms - rdata.last_due;
        due     = !(elapsed < rdata.interval);
        match   = rdata.id == item_reg.timer_id;
        case (item_reg.action)
            ptt_pkg::ACT_TICK:
            begin
                if (due && nres_reg < ptt_pkg::NRES_W'(ptt_pkg::MAX_RESULTS))
                begin
                    upd.last_due = rdata.last_due + rdata.interval;
                    if (rdata.enabled)
                    begin
                        if (rdata.limit == 16'd0)
                        begin
                            if (rdata.runs != 16'hFFFF)
                            begin
                                upd.runs = rdata.runs + 16'd1;
                            end
                            emit = 1'b1;
                        end
                        else if (rdata.runs < rdata.limit)
                        begin
                            upd.runs = rdata.runs + 16'd1;
                            rem      = !(upd.runs < rdata.limit);
                            keep     = !rem;
                            emit     = 1'b1;
                        end
                        else
                        begin
                            keep = 1'b0;
                        end
                    end
                end
            end
            ptt_pkg::ACT_DELETE:  keep = !match;
            ptt_pkg::ACT_ENABLE:  if (match) upd.enabled = 1'b1;
            ptt_pkg::ACT_DISABLE: if (match) upd.enabled = 1'b0;
            ptt_pkg::ACT_TOGGLE:  if (match) upd.enabled = !rdata.enabled;
            ptt_pkg::ACT_RESTART: if (match) upd.last_due = item_reg.now_ms;
            default: ;
        endcase
        res.result_id    = (item_reg.action == ptt_pkg::ACT_TICK) ? rdata.id
                                                                 : item_reg.timer_id;
        res.fired        = item_reg.action == ptt_pkg::ACT_TICK;
        res.removed      = rem;
        res.status       = ptt_pkg::ST_OK;
        res.enabled_out  = upd.enabled;
        res.interval_out = upd.interval;
        res.last_due_out = upd.last_due;
        res.remaining_ms = upd.last_due + upd.interval - item_reg.now_ms;
        res.elapsed_ms   = item_reg.now_ms - upd.last_due;
        res.last         = 1'b0;
    end

    logic in_acc;
    logic out_free;
    logic out_load;
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = pend_valid_reg && out_free &&
                      ((state_reg == S_EVAL && emit) || state_reg == S_WAIT);
    assign in_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic scan_end;
    assign scan_end = rd_reg >= count_reg;

    always_comb
    begin
        raddr = rd_reg[ptt_pkg::SLOT_W-1:0];
        we    = 1'b0;
        waddr = wr_reg[ptt_pkg::SLOT_W-1:0];
        wdata = upd;
        if (state_reg == S_IDLE && in_acc && in_data.action == ptt_pkg::ACT_ADD)
        begin
            we             = count_reg < ptt_pkg::CNT_W'(ptt_pkg::SLOTS);
            waddr          = count_reg[ptt_pkg::SLOT_W-1:0];
            wdata.id       = idc_reg + 16'd1;
            wdata.interval = in_data.interval_ms;
            wdata.last_due = in_data.now_ms;
            wdata.limit    = in_data.run_limit;
            wdata.runs     = 16'd0;
            wdata.enabled  = 1'b1;
        end
        else if (state_reg == S_EVAL && (!emit || !pend_valid_reg))
        begin
            we = keep;
        end
    end

    ptt_pkg::out_item_t zero_res;
    always_comb
    begin
        zero_res        = '0;
        zero_res.status = ptt_pkg::ST_NOT_FOUND;
        zero_res.result_id = item_reg.timer_id;
    end

    ptt_pkg::out_item_t add_res;
    always_comb
    begin
        add_res      = '0;
        add_res.last = 1'b1;
        if (count_reg < ptt_pkg::CNT_W'(ptt_pkg::SLOTS))
        begin
            add_res.result_id    = idc_reg + 16'd1;
            add_res.enabled_out  = 1'b1;
            add_res.interval_out = in_data.interval_ms;
            add_res.last_due_out = in_data.now_ms;
            add_res.remaining_ms = in_data.interval_ms;
        end
        else
        begin
            add_res.status = ptt_pkg::ST_FULL;
        end
    end

    ptt_pkg::out_item_t fin_res;
    always_comb
    begin
        fin_res = pend_reg;
        if (item_reg.action != ptt_pkg::ACT_TICK && !found_reg)
        begin
            fin_res = zero_res;
        end
        fin_res.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idc_reg        <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            nres_reg       <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            if (out_load)
            begin
                out_reg <= pend_reg;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        item_reg  <= in_data;
                        rd_reg    <= '0;
                        wr_reg    <= '0;
                        nres_reg  <= '0;
                        found_reg <= 1'b0;
                        if (in_data.action == ptt_pkg::ACT_ADD)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_reg       <= add_res;
                            if (count_reg < ptt_pkg::CNT_W'(ptt_pkg::SLOTS))
                            begin
                                count_reg <= count_reg + 1'b1;
                                idc_reg   <= idc_reg + 16'd1;
                            end
                            state_reg <= S_WAIT;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= scan_end ? S_FINAL : S_EVAL;
                end
                S_EVAL:
                begin
                    // one staged result: pend holds it until a later one or the end
                    if (emit && pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            pend_valid_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (emit)
                        begin
                            pend_reg       <= res;
                            pend_valid_reg <= 1'b1;
                            nres_reg       <= nres_reg + 1'b1;
                        end
                        if (item_reg.action != ptt_pkg::ACT_TICK && match && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            pend_reg  <= res;
                        end
                        if (keep)
                        begin
                            wr_reg <= wr_reg + 1'b1;
                        end
                        rd_reg    <= rd_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_FINAL:
                begin
                    count_reg <= wr_reg;
                    pend_reg  <= fin_res;
                    if (item_reg.action != ptt_pkg::ACT_TICK)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### bench/periodic_timer_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_table_checker: transaction predictor and result scoreboard
// Watches both channels, keeps its own copy of the timer table, predicts the
// results of every accepted input transaction and compares each output
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module periodic_timer_table_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ptt_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ptt_pkg::out_item_t out_data,
    output int                 errors,
    output int                 pending
);

    ptt_pkg::entry_t    tbl[ptt_pkg::SLOTS];
    int                 tbl_cnt;
    logic [15:0]        id_ctr;
    ptt_pkg::out_item_t expected_q[$];

    assign pending = expected_q.size();

    function automatic ptt_pkg::out_item_t describe(logic [15:0] id, logic f, logic r,
                                                    logic [1:0] st, ptt_pkg::entry_t e,
                                                    logic have, logic [31:0] now);
        ptt_pkg::out_item_t o;
        o = '0;
        o.result_id = id;
        o.fired = f;
        o.removed = r;
        o.status = st;
        if (have)
        begin
            o.enabled_out = e.enabled;
            o.interval_out = e.interval;
            o.last_due_out = e.last_due;
            o.remaining_ms = e.last_due + e.interval - now;
            o.elapsed_ms = now - e.last_due;
        end
        return o;
    endfunction

    task automatic enqueue(ptt_pkg::out_item_t o);
        expected_q.insert(expected_q.size(), o);
    endtask

    task automatic squeeze(bit gone[ptt_pkg::SLOTS]);
        int w;
        w = 0;
        for (int r = 0; r < tbl_cnt; r++)
        begin
            if (!gone[r])
            begin
                tbl[w] = tbl[r];
                w++;
            end
        end
        tbl_cnt = w;
    endtask

    task automatic predict_timers(ptt_pkg::in_item_t t);
        bit gone[ptt_pkg::SLOTS];
        int n;
        int first;
        bit rem;
        ptt_pkg::out_item_t o;
        ptt_pkg::entry_t blank;
        n = 0;
        first = -1;
        blank = '0;
        for (int i = 0; i < ptt_pkg::SLOTS; i++)
            gone[i] = 0;
        case (ptt_pkg::action_t'(t.action))
            ptt_pkg::ACT_TICK:
            begin
                for (int i = 0; i < tbl_cnt && n < ptt_pkg::MAX_RESULTS; i++)
                begin
                    if (t.now_ms - tbl[i].last_due < tbl[i].interval)
                        continue;
                    tbl[i].last_due += tbl[i].interval;
                    if (!tbl[i].enabled)
                        continue;
                    rem = 0;
                    if (tbl[i].limit == 0)
                    begin
                        if (tbl[i].runs != 16'hFFFF)
                            tbl[i].runs++;
                    end
                    else if (tbl[i].runs < tbl[i].limit)
                    begin
                        tbl[i].runs++;
                        rem = tbl[i].runs >= tbl[i].limit;
                    end
                    else
                    begin
                        gone[i] = 1;
                        continue;
                    end
                    gone[i] = rem;
                    o = describe(tbl[i].id, 1'b1, rem, ptt_pkg::ST_OK, tbl[i], 1'b1, t.now_ms);
                    o.last = (n == ptt_pkg::MAX_RESULTS - 1);
                    enqueue(o);
                    n++;
                end
                if (n > 0)
                    expected_q[$].last = 1;
                squeeze(gone);
            end
            ptt_pkg::ACT_ADD:
            begin
                if (tbl_cnt >= ptt_pkg::SLOTS)
                    o = describe(16'd0, 1'b0, 1'b0, ptt_pkg::ST_FULL, blank, 1'b0, t.now_ms);
                else
                begin
                    id_ctr++;
                    tbl[tbl_cnt] = '{id: id_ctr, interval: t.interval_ms, last_due: t.now_ms,
                                     limit: t.run_limit, runs: 16'd0, enabled: 1'b1};
                    o = describe(id_ctr, 1'b0, 1'b0, ptt_pkg::ST_OK, tbl[tbl_cnt], 1'b1,
                                 t.now_ms);
                    tbl_cnt++;
                end
                o.last = 1;
                enqueue(o);
            end
            default:
            begin
                for (int i = 0; i < tbl_cnt; i++)
                begin
                    if (tbl[i].id != t.timer_id)
                        continue;
                    case (ptt_pkg::action_t'(t.action))
                        ptt_pkg::ACT_DELETE:  gone[i] = 1;
                        ptt_pkg::ACT_ENABLE:  tbl[i].enabled = 1;
                        ptt_pkg::ACT_DISABLE: tbl[i].enabled = 0;
                        ptt_pkg::ACT_TOGGLE:  tbl[i].enabled = !tbl[i].enabled;
                        ptt_pkg::ACT_RESTART: tbl[i].last_due = t.now_ms;
                        default: ;
                    endcase
                    if (first < 0)
                        first = i;
                end
                if (first < 0)
                    o = describe(t.timer_id, 1'b0, 1'b0, ptt_pkg::ST_NOT_FOUND, blank, 1'b0,
                                 t.now_ms);
                else
                    o = describe(t.timer_id, 1'b0, 1'b0, ptt_pkg::ST_OK, tbl[first], 1'b1,
                                 t.now_ms);
                o.last = 1;
                enqueue(o);
                if (t.action == ptt_pkg::ACT_DELETE)
                    squeeze(gone);
            end
        endcase
    endtask

    task automatic compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        tbl_cnt = 0;
        id_ctr = '0;
    end

    always @(posedge clk)
    begin
        ptt_pkg::out_item_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transaction, id %0h", out_data.result_id);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    compare("result_id", 32'(e.result_id), 32'(out_data.result_id));
                    compare("fired", 32'(e.fired), 32'(out_data.fired));
                    compare("removed", 32'(e.removed), 32'(out_data.removed));
                    compare("status", 32'(e.status), 32'(out_data.status));
                    compare("enabled_out", 32'(e.enabled_out), 32'(out_data.enabled_out));
                    compare("interval_out", e.interval_out, out_data.interval_out);
                    compare("last_due_out", e.last_due_out, out_data.last_due_out);
                    compare("remaining_ms", e.remaining_ms, out_data.remaining_ms);
                    compare("elapsed_ms", e.elapsed_ms, out_data.elapsed_ms);
                    compare("last", 32'(e.last), 32'(out_data.last));
                end
            end
            if (in_valid && in_ready)
                predict_timers(in_data);
        end
    end

endmodule

### bench/periodic_timer_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_table_core_test: top-level testbench
// Drives directed and random timer commands (adds, ticks, id operations)
// with random idle bursts on both sides; the checker predicts and scores
// every result transaction.
// ----------------------------------------------------------------------------
module periodic_timer_table_core_test;

    localparam int WATCHDOG = 20000;
    localparam int RANDOM_ITEMS = 350;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ptt_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    ptt_pkg::out_item_t out_data;
    int                 errors;
    int                 pending;
    bit                 calm;
    int                 idle_cycles;
    logic [31:0]        clock_ms;

    periodic_timer_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    periodic_timer_table_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ready <= 1;
            repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    end

    // called at a falling edge; valid stays high into the next call
    task automatic send(ptt_pkg::action_t a, logic [31:0] now, logic [15:0] id,
                        logic [31:0] ivl, logic [15:0] lim);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= '{action: a, now_ms: now, timer_id: id, interval_ms: ivl, run_limit: lim};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_interval();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    function automatic logic [15:0] rand_limit();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($urandom);
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    initial
    begin
        ptt_pkg::action_t a;
        logic [15:0] id;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        calm = 0;
        idle_cycles = 0;
        clock_ms = 32'hFFFF_FF00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(ptt_pkg::ACT_TICK, 32'd0, 16'd0, 32'd0, 16'd0);
        send(ptt_pkg::ACT_QUERY, 32'd5, 16'hFFFF, 32'd0, 16'd0);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'd0, 32'd0, 16'd0);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'd0, 32'd10, 16'd1);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'd0, 32'd20, 16'd2);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'd0, 32'd5, 16'd0);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'd0, 32'd0, 16'd3);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'd0, 32'd1, 16'd0);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'd0, 32'd0, 16'd0);
        send(ptt_pkg::ACT_ADD, clock_ms, 16'd0, 32'd7, 16'd1);
        send(ptt_pkg::ACT_DISABLE, clock_ms, 16'd7, 32'd0, 16'd0);
        send(ptt_pkg::ACT_TOGGLE, clock_ms, 16'd6, 32'd0, 16'd0);
        send(ptt_pkg::ACT_TOGGLE, clock_ms, 16'd6, 32'd0, 16'd0);
        send(ptt_pkg::ACT_ENABLE, clock_ms, 16'd9, 32'd0, 16'd0);
        send(ptt_pkg::ACT_TICK, clock_ms + 32'd300, 16'd0, 32'd0, 16'd0);
        send(ptt_pkg::ACT_TICK, clock_ms + 32'd301, 16'd0, 32'd0, 16'd0);
        send(ptt_pkg::ACT_RESTART, 32'hFFFF_FFFF, 16'd5, 32'd0, 16'd0);
        send(ptt_pkg::ACT_QUERY, 32'd3, 16'd5, 32'd0, 16'd0);
        send(ptt_pkg::ACT_DELETE, 32'd3, 16'd1, 32'd0, 16'd0);
        send(ptt_pkg::ACT_DELETE, 32'd3, 16'd1, 32'd0, 16'd0);
        clock_ms = 32'd400;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n > RANDOM_ITEMS - 40)
                calm = 1;
            clock_ms += $urandom_range(0, 25);
            a = ptt_pkg::action_t'($urandom_range(0, 9) > 7 ? $urandom_range(2, 7) :
                ($urandom_range(0, 2) == 0 ? ptt_pkg::ACT_ADD : ptt_pkg::ACT_TICK));
            id = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
            if ($urandom_range(0, 1))
                id = checker_i.tbl_cnt > 0 ?
                     checker_i.tbl[$urandom_range(0, checker_i.tbl_cnt - 1)].id : id;
            send(a, ($urandom_range(0, 30) == 0) ? 32'($urandom) : clock_ms, id,
                 rand_interval(), rand_limit());
        end
        in_valid <= 0;

        calm = 1;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_table_ram.sv
hw/rtl/periodic_timer_table_core.sv
bench/periodic_timer_table_checker.sv
bench/periodic_timer_table_core_test.sv
